// ----- src/assert_macros.svh -----
// assertion macros used by the cursor sequence store rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising clk outside reset
`define CSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked at every rising clk outside reset
`define CSS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CSS_ASSERT_IMP(lbl, ante, cons)
`define CSS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- src/css_pkg.sv -----
// constants, codes and types of the cursor sequence store
`default_nettype none

package css_pkg;

    localparam int DEPTH  = 64;
    localparam int WIDTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int KIND_W  = 3;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    localparam logic [KIND_W-1:0] KIND_START      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADVANCE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_BEFORE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INS_AFTER  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_GET        = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_CURRENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 2'd2;

    typedef logic signed [WIDTH-1:0]  word_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;

endpackage

`default_nettype wire

// ----- src/css_if.sv -----
// command and response channel interfaces of the cursor sequence store
`default_nettype none

interface css_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic        [css_pkg::KIND_W-1:0]    kind;
    logic signed [css_pkg::DATA_W-1:0]    entry;

    modport source (output valid, output kind, output entry, input ready);
    modport sink   (input valid, input kind, input entry, output ready);
endinterface

interface css_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [css_pkg::DATA_W-1:0]    current_value;
    logic                                 has_current;
    logic        [css_pkg::COUNT_W-1:0]   item_count;
    logic        [css_pkg::STAT_W-1:0]    status;

    modport source (output valid, output current_value, output has_current,
                    output item_count, output status, input ready);
    modport sink   (input valid, input current_value, input has_current,
                    input item_count, input status, output ready);
endinterface

`default_nettype wire

// ----- src/css_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
`default_nettype none

module css_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
    input  wire logic [W-1:0]                         wdata,
    input  wire logic                                 re,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
    output logic      [W-1:0]                         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/cursor_sequence_store.sv -----
// top level of the cursor sequence store: sequencer around the item ram
//
// usage
//   cmd carries one word per operation: kind (start, advance, insert before,
//   insert after, remove, get) and entry, the value for the two inserts.
//   rsp returns exactly one word per command: the value at the cursor
//   after the operation (zero if none), has_current, item_count and status
//   (ok, no current item, store full and insert refused).
//   the list lives in one item ram; inserts and removes move the entries
//   behind the insert or remove point one place, one entry per cycle.
//   order of steps: start, advance, get, other kinds and refused ops read the
//     item at the cursor and then load the response word; an insert first
//     moves the entries, then writes the new entry, then reads; a remove moves.
//   one command is in flight at a time; cmd.ready returns the cycle after
//   the response word is loaded.
//   if rsp is stalled the loaded word waits in the output register and the
//   next finished one in the sequencer; nothing is lost or repeated.
//   reset empties the list and leaves nothing current; the ram needs no
//   clearing pass since only entries below the count are ever read.
`default_nettype none
`include "assert_macros.svh"

module cursor_sequence_store (
    input  wire logic  clk,
    input  wire logic  rst_n,
    css_cmd_if.sink    cmd,
    css_rsp_if.source  rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_PUT   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam css_pkg::cnt_t CNT_FULL = css_pkg::CNT_W'(css_pkg::DEPTH);
    localparam css_pkg::cnt_t CNT_ONE  = css_pkg::CNT_W'(1);

    // sequencer state
    logic [2:0]                   state_reg, state_next;
    css_pkg::cnt_t                total_reg, total_next;
    css_pkg::cnt_t                cursor_reg, cursor_next;
    css_pkg::cnt_t                left_reg, left_next;
    css_pkg::addr_t               src_reg, src_next;
    css_pkg::addr_t               wr_addr_reg, wr_addr_next;
    logic                         wr_pend_reg, wr_pend_next;
    logic                         up_reg, up_next;
    logic                         ins_reg, ins_next;
    logic [css_pkg::STAT_W-1:0]   status_reg, status_next;
    css_pkg::word_t               ent_reg, ent_next;

    // output register
    logic                         ov_reg, ov_next;
    css_pkg::data_t               val_reg, val_next;
    logic                         hc_reg, hc_next;
    logic [css_pkg::COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [css_pkg::STAT_W-1:0]   st_reg, st_next;

    // ram ports
    logic                         ram_we;
    css_pkg::addr_t               ram_waddr;
    logic [css_pkg::WIDTH-1:0]    ram_wdata;
    logic                         ram_re;
    css_pkg::addr_t               ram_raddr;
    logic [css_pkg::WIDTH-1:0]    ram_rdata;

    logic                         accept;
    logic                         cur;
    logic                         full;
    logic                         load_out;
    logic                         ins_cmd;
    css_pkg::cnt_t                ins_pos;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign cur       = (cursor_reg < total_reg);
    assign full      = (total_reg == CNT_FULL);
    assign load_out  = (state_reg == S_DONE) && (!ov_reg || rsp.ready);
    assign ins_cmd   = (cmd.kind == css_pkg::KIND_INS_BEFORE) ||
                       (cmd.kind == css_pkg::KIND_INS_AFTER);

    // insert point: before the current item or at the front, after it or at the end
    always_comb
    begin
        if (cmd.kind == css_pkg::KIND_INS_BEFORE)
        begin
            ins_pos = cur ? cursor_reg : '0;
        end
        else
        begin
            ins_pos = cur ? (cursor_reg + CNT_ONE) : total_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        total_next   = total_reg;
        cursor_next  = cursor_reg;
        left_next    = left_reg;
        src_next     = src_reg;
        wr_addr_next = wr_addr_reg;
        wr_pend_next = wr_pend_reg;
        up_next      = up_reg;
        ins_next     = ins_reg;
        status_next  = status_reg;
        ent_next     = ent_reg;
        ram_we       = 1'b0;
        ram_waddr    = wr_addr_reg;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = src_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next  = css_pkg::ST_OK;
                    wr_pend_next = 1'b0;
                    state_next   = S_READ;
                    case (cmd.kind)
                        css_pkg::KIND_START:
                        begin
                            cursor_next = '0;
                        end
                        css_pkg::KIND_ADVANCE:
                        begin
                            if (!cur)
                            begin
                                status_next = css_pkg::ST_NO_CURRENT;
                            end
                            else
                            begin
                                cursor_next = cursor_reg + CNT_ONE;
                            end
                        end
                        css_pkg::KIND_INS_BEFORE, css_pkg::KIND_INS_AFTER:
                        begin
                            if (full)
                            begin
                                status_next = css_pkg::ST_FULL;
                            end
                            else
                            begin
                                // move entries pos..total-1 up one place, top first
                                left_next   = total_reg - ins_pos;
                                src_next    = css_pkg::ADDR_W'(total_reg - CNT_ONE);
                                up_next     = 1'b0;
                                ins_next    = 1'b1;
                                ent_next    = css_pkg::word_t'(cmd.entry);
                                total_next  = total_reg + CNT_ONE;
                                cursor_next = ins_pos;
                                state_next  = S_SHIFT;
                            end
                        end
                        css_pkg::KIND_REMOVE:
                        begin
                            if (!cur)
                            begin
                                status_next = css_pkg::ST_NO_CURRENT;
                            end
                            else
                            begin
                                // move entries cursor+1..total-1 down one place
                                left_next  = total_reg - cursor_reg - CNT_ONE;
                                src_next   = css_pkg::ADDR_W'(cursor_reg + CNT_ONE);
                                up_next    = 1'b1;
                                ins_next   = 1'b0;
                                total_next = total_reg - CNT_ONE;
                                state_next = S_SHIFT;
                            end
                        end
                        css_pkg::KIND_GET:
                        begin
                            if (!cur)
                            begin
                                status_next = css_pkg::ST_NO_CURRENT;
                            end
                        end
                        default:
                        begin
                            status_next = css_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // write back the word read last cycle next to where it came from
                ram_we = wr_pend_reg;
                if (left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = src_reg;
                    wr_pend_next = 1'b1;
                    wr_addr_next = up_reg ? (src_reg - 1'b1) : (src_reg + 1'b1);
                    src_next     = up_reg ? (src_reg + 1'b1) : (src_reg - 1'b1);
                    left_next    = left_reg - CNT_ONE;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    state_next   = ins_reg ? S_PUT : S_READ;
                end
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cursor_reg[css_pkg::ADDR_W-1:0];
                ram_wdata  = ent_reg;
                state_next = S_READ;
            end
            S_READ:
            begin
                ram_re     = cur;
                ram_raddr  = cursor_reg[css_pkg::ADDR_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response word built from the state after the operation
    always_comb
    begin
        ov_next  = ov_reg;
        val_next = val_reg;
        hc_next  = hc_reg;
        cnt_next = cnt_reg;
        st_next  = st_reg;
        if (rsp.valid && rsp.ready)
        begin
            ov_next = 1'b0;
        end
        if (load_out)
        begin
            ov_next  = 1'b1;
            val_next = cur ? css_pkg::data_t'(signed'(ram_rdata)) : '0;
            hc_next  = cur;
            cnt_next = css_pkg::COUNT_W'(total_reg);
            st_next  = status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            cursor_reg  <= CNT_ONE;
            left_reg    <= '0;
            wr_pend_reg <= 1'b0;
            up_reg      <= 1'b0;
            ins_reg     <= 1'b0;
            status_reg  <= css_pkg::ST_OK;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            cursor_reg  <= cursor_next;
            left_reg    <= left_next;
            wr_pend_reg <= wr_pend_next;
            up_reg      <= up_next;
            ins_reg     <= ins_next;
            status_reg  <= status_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        wr_addr_reg <= wr_addr_next;
        ent_reg     <= ent_next;
        val_reg     <= val_next;
        hc_reg      <= hc_next;
        cnt_reg     <= cnt_next;
        st_reg      <= st_next;
    end

    css_ram #(
        .W (css_pkg::WIDTH),
        .D (css_pkg::DEPTH)
    ) u_item_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp.valid         = ov_reg;
    assign rsp.current_value = val_reg;
    assign rsp.has_current   = hc_reg;
    assign rsp.item_count    = cnt_reg;
    assign rsp.status        = st_reg;

    // count never passes capacity
    `CSS_ASSERT_IMP(a_total_cap, 1'b1, total_reg <= CNT_FULL)
    // an accepted insert into a store with room grows the count by one
    `CSS_ASSERT_NXT(a_ins_grow, accept && !full && ins_cmd, total_reg == $past(total_reg) + CNT_ONE)
    // an accepted remove of a current item shrinks the count by one
    `CSS_ASSERT_NXT(a_rem_shrink, accept && cur && cmd.kind == css_pkg::KIND_REMOVE, total_reg == $past(total_reg) - CNT_ONE)
    // a no-current status never comes with a current item
    `CSS_ASSERT_IMP(a_nocur_flag, rsp.valid && rsp.status == css_pkg::ST_NO_CURRENT, !rsp.has_current)
    // the ram is never written outside the shift and put steps
    `CSS_ASSERT_IMP(a_we_phase, ram_we, state_reg == S_SHIFT || state_reg == S_PUT)

endmodule

`default_nettype wire

// ----- verif/css_store_checker.sv -----
// checker for the cursor sequence store: predicts each response word and compares it
`timescale 1ns / 100ps

module css_store_checker
    import css_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    css_cmd_if   cmd,
    css_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    typedef struct {
        data_t              value;
        logic               has_current;
        logic [COUNT_W-1:0] count;
        logic [STAT_W-1:0]  status;
    } store_rsp_t;

    // shadow copy of the list and its cursor
    word_t shadow_items [DEPTH];
    int    shadow_total;
    int    shadow_cursor;

    store_rsp_t predicted_rsp [$];

    function automatic store_rsp_t predict_rsp(logic [KIND_W-1:0] op, data_t value);
        store_rsp_t r;
        int         pos;
        r.status = ST_OK;
        case (op)
            KIND_START:
                shadow_cursor = 0;
            KIND_ADVANCE:
                if (shadow_cursor < shadow_total)
                    shadow_cursor++;
                else
                    r.status = ST_NO_CURRENT;
            KIND_INS_BEFORE, KIND_INS_AFTER:
                if (shadow_total >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (op == KIND_INS_BEFORE)
                        pos = (shadow_cursor < shadow_total) ? shadow_cursor : 0;
                    else
                        pos = (shadow_cursor < shadow_total) ? shadow_cursor + 1 : shadow_total;
                    for (int i = shadow_total; i > pos; i--)
                        shadow_items[i] = shadow_items[i-1];
                    shadow_items[pos] = value;
                    shadow_total++;
                    shadow_cursor = pos;
                end
            KIND_REMOVE:
                if (shadow_cursor < shadow_total)
                begin
                    for (int i = shadow_cursor; i + 1 < shadow_total; i++)
                        shadow_items[i] = shadow_items[i+1];
                    shadow_total--;
                end
                else
                    r.status = ST_NO_CURRENT;
            KIND_GET:
                if (shadow_cursor >= shadow_total)
                    r.status = ST_NO_CURRENT;
            default:
                ;
        endcase
        if (shadow_cursor < shadow_total)
        begin
            r.value       = data_t'(shadow_items[shadow_cursor]);
            r.has_current = 1'b1;
        end
        else
        begin
            r.value       = '0;
            r.has_current = 1'b0;
        end
        r.count = shadow_total[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic signed [63:0] got,
                                   logic signed [63:0] want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        store_rsp_t want;
        if (!rst_n)
        begin
            shadow_total  = 0;
            shadow_cursor = 1;
            mismatches    = 0;
            predicted_rsp.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_rsp.size() == 0)
                    report_mismatch("unexpected response word", rsp.status, -1);
                else
                begin
                    want = predicted_rsp.pop_front();
                    if (rsp.current_value !== want.value)
                        report_mismatch("current_value", rsp.current_value, want.value);
                    if (rsp.has_current !== want.has_current)
                        report_mismatch("has_current", rsp.has_current, want.has_current);
                    if (rsp.item_count !== want.count)
                        report_mismatch("item_count", rsp.item_count, want.count);
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                end
            end
            if (cmd.valid && cmd.ready)
                predicted_rsp.push_back(predict_rsp(cmd.kind, cmd.entry));
            outstanding <= predicted_rsp.size();
        end
    end

endmodule

// ----- verif/cursor_sequence_store_tb.sv -----
// top of the cursor sequence store testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module cursor_sequence_store_tb;
    import css_pkg::*;

    // kind codes the block must ignore
    localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

    // cycles with no word moving on either channel before the run is called hung
    // (longer than the worst insert and the long receiver hold)
    localparam int HANG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;

    css_cmd_if cmd_ch ();
    css_rsp_if rsp_ch ();

    int mismatches;
    int outstanding;

    // idle percentages for the two sides, changed per phase
    int send_idle;
    int recv_idle;

    // hold-off request for the receiver, taken up once by the ready process
    logic hold_request;
    logic hold_taken;
    int   hold_left;

    int quiet_cycles;

    cursor_sequence_store dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    css_store_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 20 ns period
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // receiver side: random stalls, plus a long hold-off when one is requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    = 0;
            hold_taken   = 1'b0;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (hold_request && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // hang watchdog: counts cycles in which no word is accepted anywhere
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("watchdog: no word accepted for %0d cycles", HANG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // offer one command word, with a random gap in front, and wait until taken
    task automatic send_word(input logic [KIND_W-1:0] op, input data_t value);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind  <= op;
        cmd_ch.entry <= value;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
    endtask

    // insert value: mostly random, sometimes the extremes and bit patterns
    function automatic data_t pick_entry();
        case ($urandom_range(15))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return '1;
            4:       return 32'sh55555555;
            5:       return 32'shaaaaaaaa;
            default: return $urandom;
        endcase
    endfunction

    // weighted mix of all operations, inserts favored so the list grows
    task automatic send_mixed_op();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            send_word(KIND_INS_BEFORE, pick_entry());
        else if (r < 42)
            send_word(KIND_INS_AFTER, pick_entry());
        else if (r < 60)
            send_word(KIND_REMOVE, $urandom);
        else if (r < 70)
            send_word(KIND_START, $urandom);
        else if (r < 85)
            send_word(KIND_ADVANCE, $urandom);
        else if (r < 95)
            send_word(KIND_GET, $urandom);
        else
            send_word($urandom_range(1) ? KIND_UNUSED_7 : KIND_UNUSED_6, $urandom);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        send_idle     = 0;
        recv_idle     = 0;
        hold_request  = 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.kind  <= KIND_START;
        cmd_ch.entry <= '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the first idle mix
        send_idle = 10;
        recv_idle = 82;

        // nothing current on an empty store
        send_word(KIND_GET, '0);
        send_word(KIND_ADVANCE, '1);
        send_word(KIND_REMOVE, '0);
        // start on an empty store still leaves nothing current
        send_word(KIND_START, '1);
        // insert-after with nothing current appends, insert-before goes at the cursor
        send_word(KIND_INS_AFTER, 32'sh7fffffff);
        send_word(KIND_INS_BEFORE, 32'sh80000000);
        send_word(KIND_INS_AFTER, '0);
        send_word(KIND_INS_AFTER, '1);
        send_word(KIND_START, '0);
        send_word(KIND_GET, '0);
        // walk off the end, then one advance too many
        send_word(KIND_ADVANCE, '0);
        send_word(KIND_ADVANCE, '0);
        send_word(KIND_ADVANCE, '0);
        send_word(KIND_ADVANCE, '0);
        send_word(KIND_ADVANCE, '0);
        // insert-before with nothing current goes to the front
        send_word(KIND_INS_BEFORE, 32'sh55555555);
        send_word(KIND_INS_AFTER, 32'shaaaaaaaa);
        send_word(KIND_REMOVE, '0);
        send_word(KIND_GET, '0);
        // unused kinds change nothing
        send_word(KIND_UNUSED_6, 32'sh12345678);
        send_word(KIND_UNUSED_7, '1);
        // remove inside the list leaves the next item current
        send_word(KIND_START, '0);
        send_word(KIND_ADVANCE, '0);
        send_word(KIND_ADVANCE, '0);
        send_word(KIND_ADVANCE, '0);
        send_word(KIND_REMOVE, '0);

        // random part in three idle mixes; each phase also pushes the store
        // toward full with an insert burst and then drains part of it
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 10;
                    recv_idle = 82;
                end
                1:
                begin
                    send_idle = 82;
                    recv_idle = 10;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase

            repeat (20) send_mixed_op();

            // receiver holds off while the sender keeps offering words,
            // so the block's output stalls and cmd.ready stays low
            if (phase == 0)
                hold_request = 1'b1;

            // fill burst: mostly inserts with an occasional advance, to push the store toward full
            repeat (68)
            begin
                if ($urandom_range(9) == 0)
                    send_word(KIND_ADVANCE, $urandom);
                else
                    send_word($urandom_range(1) ? KIND_INS_AFTER : KIND_INS_BEFORE,
                              pick_entry());
            end
            send_word(KIND_GET, '0);

            // drain from the front with a few cursor moves in between
            send_word(KIND_START, $urandom);
            repeat (35)
            begin
                if ($urandom_range(9) < 2)
                    send_word(KIND_ADVANCE, $urandom);
                else
                    send_word(KIND_REMOVE, $urandom);
            end

            repeat (20) send_mixed_op();
        end

        cmd_ch.valid <= 1'b0;
        @(posedge clk);

        // let every expected response word arrive, then a short tail
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
